FILE: hw/rtl/u2u_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package u2u_pkg;

    localparam int unsigned POINT_W = 21;
    localparam int unsigned UNIT_W  = 16;

    localparam logic [UNIT_W-1:0]  HI_SURR_BASE = 16'hD800;
    localparam logic [UNIT_W-1:0]  LO_SURR_BASE = 16'hDC00;
    localparam logic [POINT_W-1:0] SURR_FIRST   = 21'h00D800;
    localparam logic [POINT_W-1:0] SURR_LAST    = 21'h00DFFF;
    localparam logic [POINT_W-1:0] MIN_TWO      = 21'h000080;
    localparam logic [POINT_W-1:0] MIN_THREE    = 21'h000800;
    localparam logic [POINT_W-1:0] MIN_FOUR     = 21'h010000;
    localparam logic [POINT_W-1:0] MAX_POINT    = 21'h10FFFF;
    localparam logic [POINT_W-1:0] PLANE_OFFSET = 21'h010000;

    localparam logic [1:0] SEQ_TWO   = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR  = 2'd3;

    typedef struct packed {
        logic [1:0]         pending;
        logic [1:0]         seq_len;
        logic [POINT_W-1:0] point;
        logic               dropping;
    } state_t;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              bad_input;
        logic              string_done;
        logic              run_last;
    } result_t;

endpackage

FILE: hw/rtl/u2u_if.sv
// Channel interfaces: UTF-8 byte input and UTF-16 unit output.
interface u2u_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       final_byte;

    modport source (output valid, output byte_in, output final_byte, input ready);
    modport sink   (input valid, input byte_in, input final_byte, output ready);
endinterface

interface u2u_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        bad_input;
    logic        string_done;
    logic        run_last;

    modport source (output valid, output code_unit, output bad_input,
                    output string_done, output run_last, input ready);
    modport sink   (input valid, input code_unit, input bad_input,
                    input string_done, input run_last, output ready);
endinterface

FILE: hw/rtl/u2u_step.sv
// Per-byte decode: next state and up to two results from one byte.
module u2u_step
(
    input  u2u_pkg::state_t  st,
    input  logic [7:0]       byte_in,
    input  logic             final_byte,
    output u2u_pkg::state_t  st_next,
    output logic [1:0]       res_cnt,
    output u2u_pkg::result_t res0,
    output u2u_pkg::result_t res1
);

    logic                          rej;
    logic                          emit;
    logic [u2u_pkg::POINT_W-1:0]   cp;
    logic [u2u_pkg::POINT_W-1:0]   pt;
    logic [u2u_pkg::POINT_W-1:0]   cpm;
    logic [1:0]                    pend_dec;

    always_comb
    begin
        pt       = {st.point[u2u_pkg::POINT_W-7:0], byte_in[5:0]};
        pend_dec = st.pending - 2'd1;
        st_next  = st;
        rej      = 1'b0;
        emit     = 1'b0;
        cp       = pt;

        if (st.dropping)
        begin
            if (final_byte)
                st_next = '0;
        end
        else if (st.pending == 2'd0)
        begin
            if (!byte_in[7])
            begin
                emit = 1'b1;
                cp   = {13'd0, byte_in};
            end
            else if (byte_in[7:5] == 3'b110)
            begin
                st_next.seq_len = u2u_pkg::SEQ_TWO;
                st_next.pending = u2u_pkg::SEQ_TWO;
                st_next.point   = {16'd0, byte_in[4:0]};
                rej             = final_byte;
            end
            else if (byte_in[7:4] == 4'b1110)
            begin
                st_next.seq_len = u2u_pkg::SEQ_THREE;
                st_next.pending = u2u_pkg::SEQ_THREE;
                st_next.point   = {17'd0, byte_in[3:0]};
                rej             = final_byte;
            end
            else if (byte_in[7:3] == 5'b11110)
            begin
                st_next.seq_len = u2u_pkg::SEQ_FOUR;
                st_next.pending = u2u_pkg::SEQ_FOUR;
                st_next.point   = {18'd0, byte_in[2:0]};
                rej             = final_byte;
            end
            else
            begin
                rej = 1'b1;
            end
        end
        else if (byte_in[7:6] != 2'b10)
        begin
            rej = 1'b1;
        end
        else
        begin
            st_next.point   = pt;
            st_next.pending = pend_dec;
            if (pend_dec != 2'd0)
            begin
                rej = final_byte;
            end
            else
            begin
                case (st.seq_len)
                    u2u_pkg::SEQ_TWO:
                        rej = (pt < u2u_pkg::MIN_TWO);
                    u2u_pkg::SEQ_THREE:
                        rej = (pt < u2u_pkg::MIN_THREE) ||
                              ((pt >= u2u_pkg::SURR_FIRST) && (pt <= u2u_pkg::SURR_LAST));
                    default:
                        rej = (pt < u2u_pkg::MIN_FOUR) || (pt > u2u_pkg::MAX_POINT);
                endcase
                emit            = !rej;
                st_next.seq_len = 2'd0;
                st_next.point   = '0;
            end
        end

        // Reject also clears the state; dropping holds until the last byte.
        if (rej)
        begin
            st_next          = '0;
            st_next.dropping = !final_byte;
        end
    end

    always_comb
    begin
        cpm     = cp - u2u_pkg::PLANE_OFFSET;
        res_cnt = 2'd0;
        res0    = '0;
        res1    = '0;
        if (rej)
        begin
            res_cnt = 2'd1;
            res0    = '{code_unit: '0, bad_input: 1'b1, string_done: 1'b0, run_last: 1'b1};
        end
        else if (emit)
        begin
            if (cp[u2u_pkg::POINT_W-1:16] == '0)
            begin
                res_cnt = 2'd1;
                res0    = '{code_unit: cp[15:0], bad_input: 1'b0,
                            string_done: final_byte, run_last: 1'b1};
            end
            else
            begin
                res_cnt = 2'd2;
                res0    = '{code_unit: u2u_pkg::HI_SURR_BASE | {6'd0, cpm[19:10]},
                            bad_input: 1'b0, string_done: 1'b0, run_last: 1'b0};
                res1    = '{code_unit: u2u_pkg::LO_SURR_BASE | {6'd0, cpm[9:0]},
                            bad_input: 1'b0, string_done: final_byte, run_last: 1'b1};
            end
        end
    end

endmodule

FILE: hw/rtl/utf8_to_utf16_decoder_top.sv
// Validating UTF-8 to UTF-16 decoder top level.
//
//  channel   dir  payload                                      handshake
//  byte_ch   in   byte_in[7:0], final_byte                     valid/ready
//  unit_ch   out  code_unit[15:0], bad_input, string_done,     valid/ready
//                 run_last
//
// One byte is accepted per cycle while the output is ready; a byte that yields
// a surrogate pair holds the input while the two-entry result buffer drains.
// A byte passes through the input register, then the result buffer, before its first result is offered.
// rst_n clears the decode state and empties both register stages.
// A stalled output backs up into the input register, then into byte_ch.ready.
module utf8_to_utf16_decoder_top
(
    input  logic               clk,
    input  logic               rst_n,
    u2u_byte_if.sink           byte_ch,
    u2u_unit_if.source         unit_ch
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_final_reg;
    u2u_pkg::state_t    state_reg;
    u2u_pkg::state_t    state_next;
    logic [1:0]         out_cnt_reg;
    u2u_pkg::result_t   res0_reg;
    u2u_pkg::result_t   res1_reg;

    logic [1:0]         step_cnt;
    u2u_pkg::result_t   step_res0;
    u2u_pkg::result_t   step_res1;
    logic               out_fire;
    logic               advance;
    logic               in_fire;

    u2u_step u_step
    (
        .st         (state_reg),
        .byte_in    (in_byte_reg),
        .final_byte (in_final_reg),
        .st_next    (state_next),
        .res_cnt    (step_cnt),
        .res0       (step_res0),
        .res1       (step_res1)
    );

    assign out_fire      = unit_ch.valid && unit_ch.ready;
    assign advance       = in_valid_reg &&
                           ((out_cnt_reg == 2'd0) || ((out_cnt_reg == 2'd1) && out_fire));
    assign byte_ch.ready = !in_valid_reg || advance;
    assign in_fire       = byte_ch.valid && byte_ch.ready;

    assign unit_ch.valid       = (out_cnt_reg != 2'd0);
    assign unit_ch.code_unit   = res0_reg.code_unit;
    assign unit_ch.bad_input   = res0_reg.bad_input;
    assign unit_ch.string_done = res0_reg.string_done;
    assign unit_ch.run_last    = res0_reg.run_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
            out_cnt_reg  <= 2'd0;
        end
        else
        begin
            if (byte_ch.ready)
                in_valid_reg <= byte_ch.valid;
            if (advance)
            begin
                state_reg   <= state_next;
                out_cnt_reg <= step_cnt;
            end
            else if (out_fire)
            begin
                out_cnt_reg <= out_cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg  <= byte_ch.byte_in;
            in_final_reg <= byte_ch.final_byte;
        end
        if (advance)
        begin
            res0_reg <= step_res0;
            res1_reg <= step_res1;
        end
        else if (out_fire)
        begin
            res0_reg <= res1_reg;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (unit_ch.valid && unit_ch.bad_input) |->
            (unit_ch.code_unit == 16'd0) && !unit_ch.string_done && unit_ch.run_last)
        else $error("error result carries data");

    a_pair_head: assert property (@(posedge clk) disable iff (!rst_n)
        (out_cnt_reg == 2'd2) |->
            (res0_reg.code_unit[15:10] == 6'b110110) && !res0_reg.run_last
            && (res1_reg.code_unit[15:10] == 6'b110111) && res1_reg.run_last)
        else $error("surrogate pair malformed in buffer");

    a_drop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.dropping |-> (state_reg.pending == 2'd0) && (state_reg.seq_len == 2'd0))
        else $error("dropping with an open sequence");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_final_reg) |=> (state_reg == '0))
        else $error("state not cleared after last byte of string");

endmodule
